/* hdl/double_exact_product_split_unit_assert.svh */
// assertion macros for the exact product split unit
// used by the top level, expects a clock aclk and reset aresetn in scope
`ifndef DOUBLE_EXACT_PRODUCT_SPLIT_UNIT_ASSERT_SVH
`define DOUBLE_EXACT_PRODUCT_SPLIT_UNIT_ASSERT_SVH

// checked only out of reset
`define DPSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset as well
`define DPSU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hdl/dpsu_pkg.sv */
// shared types, constants and helper functions for the exact product split unit
// no dependencies
package dpsu_pkg;

    localparam int FRAC_BITS = 52;
    localparam int LOW_DROP  = 12;
    localparam logic [10:0] EXP_ONES  = 11'h7FF;
    localparam logic [63:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;

    // signed exponent, wide enough for every intermediate scale
    typedef logic signed [13:0] exp_t;

    // side information that travels with each word
    typedef struct packed {
        logic sign;
        logic nf;
        logic zero;
    } side_t;

    // position of the highest set bit, zero for an all-zero word
    function automatic logic [5:0] top_bit(input logic [63:0] x);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

/* hdl/dpsu_unpack.sv */
// operand decode and normalisation, two register stages
// depends on dpsu_pkg
module dpsu_unpack (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic [63:0]          a_bits,
    input  logic [63:0]          b_bits,
    output logic                 vld_out,
    output logic [63:0]          ma,
    output logic [63:0]          mb,
    output dpsu_pkg::exp_t       r_out,
    output dpsu_pkg::side_t      side_out
);
    import dpsu_pkg::*;

    logic        vld1_reg, vld2_reg;
    logic [52:0] ma1_reg, mb1_reg, ma1_next, mb1_next;
    logic [5:0]  sa1_reg, sb1_reg, sa1_next, sb1_next;
    exp_t        ea1_reg, eb1_reg, ea1_next, eb1_next;
    side_t       side1_reg, side2_reg, side1_next;
    logic [63:0] ma2_reg, mb2_reg;
    exp_t        r2_reg;

    // decode both operands and find the normalising shift
    always_comb begin
        logic [10:0] e_a, e_b;
        exp_t        q_a, q_b;
        e_a = a_bits[62:52];
        e_b = b_bits[62:52];
        ma1_next = {(e_a != 11'd0), a_bits[51:0]};
        mb1_next = {(e_b != 11'd0), b_bits[51:0]};
        sa1_next = 6'd63 - top_bit({11'd0, ma1_next});
        sb1_next = 6'd63 - top_bit({11'd0, mb1_next});
        q_a = (e_a != 11'd0) ? exp_t'({3'd0, e_a}) - exp_t'(1075) : exp_t'(-1074);
        q_b = (e_b != 11'd0) ? exp_t'({3'd0, e_b}) - exp_t'(1075) : exp_t'(-1074);
        ea1_next = q_a + exp_t'(64) - exp_t'({8'd0, sa1_next});
        eb1_next = q_b + exp_t'(64) - exp_t'({8'd0, sb1_next});
        side1_next.sign = a_bits[63] ^ b_bits[63];
        side1_next.nf   = (e_a == EXP_ONES) || (e_b == EXP_ONES);
        side1_next.zero = (a_bits[62:0] == 63'd0) || (b_bits[62:0] == 63'd0);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    // stage one: decoded fields, stage two: aligned significands and sum of exponents
    always_ff @(posedge aclk) begin
        if (en) begin
            ma1_reg   <= ma1_next;
            mb1_reg   <= mb1_next;
            sa1_reg   <= sa1_next;
            sb1_reg   <= sb1_next;
            ea1_reg   <= ea1_next;
            eb1_reg   <= eb1_next;
            side1_reg <= side1_next;
            ma2_reg   <= {11'd0, ma1_reg} << sa1_reg;
            mb2_reg   <= {11'd0, mb1_reg} << sb1_reg;
            r2_reg    <= ea1_reg + eb1_reg;
            side2_reg <= side1_reg;
        end
    end

    assign vld_out  = vld2_reg;
    assign ma       = ma2_reg;
    assign mb       = mb2_reg;
    assign r_out    = r2_reg;
    assign side_out = side2_reg;

endmodule

/* hdl/dpsu_mul.sv */
// exact 64 by 64 significand product, partial products then a final sum
// depends on dpsu_pkg
module dpsu_mul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic [63:0]          ma,
    input  logic [63:0]          mb,
    input  dpsu_pkg::exp_t       r_in,
    input  dpsu_pkg::side_t      side_in,
    output logic                 vld_out,
    output logic [63:0]          val,
    output logic [63:0]          err,
    output dpsu_pkg::exp_t       r_out,
    output dpsu_pkg::side_t      side_out
);
    import dpsu_pkg::*;

    logic         vld1_reg, vld2_reg;
    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    exp_t         r1_reg, r2_reg;
    side_t        side1_reg, side2_reg;
    logic [127:0] prod_next;
    logic [63:0]  val_reg, err_reg;

    // sum of the four partial products
    assign prod_next = {hh_reg, 64'd0} + {32'd0, lh_reg, 32'd0}
                     + {32'd0, hl_reg, 32'd0} + {64'd0, ll_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    // partial products, then truncated high part and the low remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg    <= ma[31:0]  * mb[31:0];
            lh_reg    <= ma[31:0]  * mb[63:32];
            hl_reg    <= ma[63:32] * mb[31:0];
            hh_reg    <= ma[63:32] * mb[63:32];
            r1_reg    <= r_in;
            side1_reg <= side_in;
            val_reg   <= {prod_next[127:64+LOW_DROP], LOW_DROP'(0)};
            err_reg   <= {prod_next[64+LOW_DROP-1:64], prod_next[63:LOW_DROP]};
            r2_reg    <= r1_reg;
            side2_reg <= side1_reg;
        end
    end

    assign vld_out  = vld2_reg;
    assign val      = val_reg;
    assign err      = err_reg;
    assign r_out    = r2_reg;
    assign side_out = side2_reg;

endmodule

/* hdl/dpsu_pack.sv */
// binary64 packing of x * 2^scale with round to nearest-even, three register stages
// depends on dpsu_pkg
module dpsu_pack (
    input  logic            aclk,
    input  logic            en,
    input  logic [63:0]     x,
    input  dpsu_pkg::exp_t  scale,
    output logic [62:0]     mag
);
    import dpsu_pkg::*;

    // stage a: leading bit, shift and exponent
    logic [63:0] xa_reg;
    exp_t        sha_reg, sha_next;
    logic        norma_reg, norma_next, ovfa_reg, zeroa_reg;
    logic [10:0] bexpa_reg;
    exp_t        bea_next;

    // stage b: truncated significand and rounding bits
    logic [52:0] qb_reg, qb_next;
    logic        rbb_reg, rbb_next, stb_reg, stb_next;
    logic        normb_reg, ovfb_reg, zerob_reg;
    logic [10:0] bexpb_reg;

    logic [62:0] mag_reg, mag_next;

    always_comb begin
        logic [5:0] p;
        exp_t       shift, sub;
        p          = top_bit(x);
        shift      = exp_t'({8'd0, p}) - exp_t'(FRAC_BITS);
        sub        = exp_t'(-1074) - scale;
        norma_next = !(sub > shift);
        sha_next   = norma_next ? shift : sub;
        bea_next   = exp_t'({8'd0, p}) + scale + exp_t'(1023);
    end

    // align to the 53-bit significand
    always_comb begin
        exp_t         neg;
        logic [63:0]  lsh;
        logic [127:0] t;
        neg = exp_t'(0) - sha_reg;
        lsh = xa_reg << neg[5:0];
        t   = {xa_reg, 64'd0} >> sha_reg[6:0];
        if (sha_reg <= exp_t'(0)) begin
            qb_next  = lsh[52:0];
            rbb_next = 1'b0;
            stb_next = 1'b0;
        end else if (sha_reg > exp_t'(64)) begin
            qb_next  = 53'd0;
            rbb_next = 1'b0;
            stb_next = 1'b0;
        end else begin
            qb_next  = t[116:64];
            rbb_next = t[63];
            stb_next = (t[62:0] != 63'd0);
        end
    end

    // round and assemble
    always_comb begin
        logic [53:0] qr;
        logic [63:0] bits;
        qr   = {1'b0, qb_reg} + 54'(rbb_reg && (stb_reg || qb_reg[0]));
        bits = {1'b0, bexpb_reg, 52'd0} + {10'd0, qr};
        if (zerob_reg) begin
            mag_next = 63'd0;
        end else if (!normb_reg) begin
            mag_next = {9'd0, qr};
        end else if (ovfb_reg || (bits[62:52] == EXP_ONES)) begin
            mag_next = {EXP_ONES, 52'd0};
        end else begin
            mag_next = bits[62:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg    <= x;
            sha_reg   <= sha_next;
            norma_reg <= norma_next;
            ovfa_reg  <= bea_next > exp_t'(2046);
            bexpa_reg <= bea_next[10:0] - 11'd1;
            zeroa_reg <= (x == 64'd0);
            qb_reg    <= qb_next;
            rbb_reg   <= rbb_next;
            stb_reg   <= stb_next;
            normb_reg <= norma_reg;
            ovfb_reg  <= ovfa_reg;
            bexpb_reg <= bexpa_reg;
            zerob_reg <= zeroa_reg;
            mag_reg   <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

/* hdl/double_exact_product_split_unit.sv */
// throughput: one word per cycle while the output is not stalled, set by the fully pipelined datapath
// (decode 2, significand multiply 2, pack and round 3 stages)
// a stalled output holds the whole pipeline, nothing is lost or repeated
// reset: synchronous active-low aresetn clears all valid bits, no clearing pass
`include "double_exact_product_split_unit_assert.svh"
module double_exact_product_split_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // a_bits [63:0], b_bits [127:64]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // value_bits [63:0], error_bits [127:64]
    output logic          m_tuser    // not_finite
);
    import dpsu_pkg::*;

    logic        en;
    logic        u_vld, x_vld;
    logic [63:0] ma, mb, val, err;
    exp_t        u_r, x_r;
    side_t       u_side, x_side;
    logic [62:0] val_mag, err_mag;
    logic [2:0]  pvld_reg;
    side_t       pside_reg [3];
    logic [63:0] val_word, err_word;

    // one enable for the whole pipeline
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    dpsu_unpack u_unpack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (s_tvalid),
        .a_bits   (s_tdata[63:0]),
        .b_bits   (s_tdata[127:64]),
        .vld_out  (u_vld),
        .ma       (ma),
        .mb       (mb),
        .r_out    (u_r),
        .side_out (u_side)
    );

    dpsu_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (u_vld),
        .ma       (ma),
        .mb       (mb),
        .r_in     (u_r),
        .side_in  (u_side),
        .vld_out  (x_vld),
        .val      (val),
        .err      (err),
        .r_out    (x_r),
        .side_out (x_side)
    );

    dpsu_pack u_pack_val (
        .aclk  (aclk),
        .en    (en),
        .x     (val),
        .scale (x_r - exp_t'(64)),
        .mag   (val_mag)
    );

    dpsu_pack u_pack_err (
        .aclk  (aclk),
        .en    (en),
        .x     (err),
        .scale (x_r - exp_t'(64 + FRAC_BITS)),
        .mag   (err_mag)
    );

    // valid bits and side information alongside the pack stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvld_reg <= 3'd0;
        end else if (en) begin
            pvld_reg <= {pvld_reg[1:0], x_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pside_reg[0] <= x_side;
            pside_reg[1] <= pside_reg[0];
            pside_reg[2] <= pside_reg[1];
        end
    end

    // special operands override the packed parts
    always_comb begin
        if (pside_reg[2].nf) begin
            val_word = QUIET_NAN;
            err_word = QUIET_NAN;
        end else if (pside_reg[2].zero) begin
            val_word = {pside_reg[2].sign, 63'd0};
            err_word = {pside_reg[2].sign, 63'd0};
        end else begin
            val_word = {pside_reg[2].sign, val_mag};
            err_word = {pside_reg[2].sign, err_mag};
        end
    end

    assign m_tvalid = pvld_reg[2];
    assign m_tdata  = {err_word, val_word};
    assign m_tuser  = pside_reg[2].nf;

    `DPSU_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "output valid after reset")
    `DPSU_ASSERT(a_nf_nan, m_tvalid && m_tuser |-> m_tdata == {QUIET_NAN, QUIET_NAN},
        "non-finite word without quiet nan")
    `DPSU_ASSERT(a_no_nan,
        m_tvalid && !m_tuser |-> m_tdata[62:52] != EXP_ONES || m_tdata[51:0] == 52'd0,
        "nan value part from finite operands")
    `DPSU_ASSERT(a_err_no_nan,
        m_tvalid && !m_tuser |-> m_tdata[126:116] != EXP_ONES || m_tdata[115:64] == 52'd0,
        "nan error part from finite operands")

endmodule

/* test/tb.sv */
// self-checking bench for the exact product split unit: directed and random operand pairs
// depends on dpsu_pkg and double_exact_product_split_unit
`timescale 1ns / 100ps
module tb;
    import dpsu_pkg::*;

    typedef struct {
        logic [63:0] value_bits;
        logic [63:0] error_bits;
        logic        not_finite;
    } split_t;

    // highest set bit of a nonzero word
    function automatic int msb_index(input logic [63:0] x);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                p = i;
            end
        end
        return p;
    endfunction

    // round sign and x * 2^scale to nearest-even binary64
    function automatic logic [63:0] pack_double(input logic [63:0] sgn, input logic [63:0] x,
                                                input int scale);
        int p, sh, sub_sh, be;
        bit normal;
        logic [63:0] q, rem, half, bits;
        if (x == 64'd0) begin
            return sgn;
        end
        p = msb_index(x);
        sh = p - FRAC_BITS;
        sub_sh = -1074 - scale;
        normal = 1'b1;
        if (sub_sh > sh) begin
            sh = sub_sh;
            normal = 1'b0;
        end
        if (sh <= 0) begin
            q = x << (-sh);
        end else if (sh > 64) begin
            q = 64'd0;
        end else if (sh == 64) begin
            q = (x > (64'd1 << 63)) ? 64'd1 : 64'd0;
        end else begin
            rem = x & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            q = x >> sh;
            if (rem > half || (rem == half && q[0])) begin
                q = q + 64'd1;
            end
        end
        if (!normal) begin
            return sgn | q;
        end
        be = p + scale + 1023;
        if (be > 2046) begin
            return sgn | {1'b0, EXP_ONES, 52'd0};
        end
        bits = (64'(be - 1) << FRAC_BITS) + q;
        if (bits[62:52] == EXP_ONES) begin
            return sgn | {1'b0, EXP_ONES, 52'd0};
        end
        return sgn | bits;
    endfunction

    // left-aligned significand and exponent of a finite nonzero operand
    function automatic void decode(input logic [63:0] bits, output logic [63:0] sig,
                                   output int ex);
        logic [63:0] m;
        int q, s;
        m = {12'd0, bits[51:0]};
        if (bits[62:52] != 11'd0) begin
            m[52] = 1'b1;
            q = int'(bits[62:52]) - 1075;
        end else begin
            q = -1074;
        end
        s = 63 - msb_index(m);
        sig = m << s;
        ex = q + 64 - s;
    endfunction

    // value and error parts of the exact product
    function automatic split_t split_product(input logic [63:0] a, input logic [63:0] b);
        split_t r;
        logic [63:0] sgn, sa, sb, hi, lo, val, err;
        logic [127:0] prod;
        int ea, eb;
        sgn = {a[63] ^ b[63], 63'd0};
        r.not_finite = 1'b0;
        if (a[62:52] == EXP_ONES || b[62:52] == EXP_ONES) begin
            r.value_bits = QUIET_NAN;
            r.error_bits = QUIET_NAN;
            r.not_finite = 1'b1;
        end else if (a[62:0] == 63'd0 || b[62:0] == 63'd0) begin
            r.value_bits = sgn;
            r.error_bits = sgn;
        end else begin
            decode(a, sa, ea);
            decode(b, sb, eb);
            prod = {64'd0, sa} * {64'd0, sb};
            hi = prod[127:64];
            lo = prod[63:0];
            val = hi & ~((64'd1 << LOW_DROP) - 64'd1);
            err = (hi << FRAC_BITS) | (lo >> LOW_DROP);
            r.value_bits = pack_double(sgn, val, ea + eb - 64);
            r.error_bits = pack_double(sgn, err, ea + eb - FRAC_BITS - 64);
        end
        return r;
    endfunction

    // holds the expected splits in order and compares result words
    class split_board;
        split_t pending[$];
        int     errors;

        function void note_operands(input logic [63:0] a, input logic [63:0] b);
            pending.push_back(split_product(a, b));
        endfunction

        function void check_result(input logic [63:0] v, input logic [63:0] e,
                                   input logic nf);
            split_t x;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %h %h %b", v, e, nf);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (v !== x.value_bits) begin
                $error("value_bits expected %h actual %h", x.value_bits, v);
                errors++;
            end
            if (e !== x.error_bits) begin
                $error("error_bits expected %h actual %h", x.error_bits, e);
                errors++;
            end
            if (nf !== x.not_finite) begin
                $error("not_finite expected %b actual %b", x.not_finite, nf);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    bit           busy_phase = 1'b0;
    split_board   board = new();

    double_exact_product_split_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // mostly short gaps, a few long ones, none during a busy phase
    function automatic int pick_gap();
        int r;
        if (busy_phase) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // operand biased towards useful exponent ranges and special encodings
    function automatic logic [63:0] pick_operand();
        logic [63:0] x;
        int k;
        x = {$urandom(), $urandom()};
        k = $urandom_range(0, 19);
        if (k < 11) begin
            x[62:52] = 11'($urandom_range(1023 - 300, 1023 + 300));
        end else if (k < 13) begin
            x[62:52] = 11'd0;
            if ($urandom_range(0, 1)) x[51:0] = x[51:0] >> $urandom_range(0, 51);
        end else if (k < 15) begin
            x[62:52] = $urandom_range(0, 1) ? 11'($urandom_range(1, 40))
                                            : 11'($urandom_range(2000, 2046));
        end else if (k == 15) begin
            x[62:0] = $urandom_range(0, 1) ? {EXP_ONES, 52'd0} : 63'd0;
        end else if (k == 16) begin
            x[62:52] = EXP_ONES;
        end
        return x;
    endfunction

    // one input word, held until accepted
    task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, a};
        do @(posedge aclk); while (!s_tready);
        board.note_operands(a, b);
    endtask

    // result words checked on every handshake
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata[63:0], m_tdata[127:64], m_tuser);
        end
    end

    // result side back-pressure
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            gap = pick_gap();
            repeat (gap) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // run limit
    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [63:0] da[$];
        logic [63:0] db[$];
        da = '{64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
               64'h7FF0_0000_0000_0000, 64'hFFF8_0000_0000_0001, 64'h0000_0000_0000_0001,
               64'h000F_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
               64'h3FF0_0000_0000_0001, 64'hBFFF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
               64'h7FEF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000, 64'h3FB9_9999_9999_999A,
               64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 64'h4340_0000_0000_0001,
               64'h001F_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF};
        db = '{64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
               64'h0000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
               64'h000F_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
               64'h3FF0_0000_0000_0001, 64'h3FFF_FFFF_FFFF_FFFF, 64'h3CA0_0000_0000_0000,
               64'h3FF0_0000_0000_0001, 64'h8000_0000_0000_0000, 64'h3FB9_9999_9999_999A,
               64'h0000_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'h4340_0000_0000_0003,
               64'h3C9F_FFFF_FFFF_FFFF, 64'h8010_0000_0000_0001};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed extremes and special encodings
        foreach (da[i]) send_pair(da[i], db[i]);

        // random pairs, with two busy stretches and a full drain midway
        for (int n = 0; n < 1600; n++) begin
            busy_phase = (n >= 300 && n < 450) || (n >= 1200 && n < 1260);
            if (n == 800) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (board.pending.size() != 0) @(posedge aclk);
            end
            send_pair(pick_operand(), pick_operand());
        end
        busy_phase = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
